[hw/rtl/range_add_range_max_tree_assert.svh]
// Assertion macros shared by the range-add range-maximum tree checkers.
`ifndef RANGE_ADD_RANGE_MAX_TREE_ASSERT_SVH
`define RANGE_ADD_RANGE_MAX_TREE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RATREE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("range tree assertion failed");

// Next-cycle implication, checked outside reset.
`define RATREE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("range tree assertion failed");

// Next-cycle implication, checked at every edge including reset.
`define RATREE_ASSERT_NEXT_ALL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("range tree assertion failed");

`endif

[hw/rtl/ratree_pkg.sv]
// Shared constants, types and helpers of the range-add range-maximum tree.
package ratree_pkg;

    localparam int LEAVES  = 1024;
    localparam int LEVELS  = $clog2(LEAVES);
    localparam int IDX_W   = LEVELS;
    localparam int CNT_W   = LEVELS + 1;
    localparam int NODE_AW = LEVELS + 1;
    localparam int NODES   = 2 * LEAVES;
    localparam int LVL_W   = $clog2(LEVELS + 1);
    localparam int VAL_W   = 64;
    localparam int AMT_W   = 32;
    localparam int MODE_W  = 2;

    localparam logic [MODE_W-1:0] MODE_SET   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(LEAVES);

    // One accepted operation as handed to the tree walker.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  lo;
        logic [IDX_W-1:0]  hi;
        logic [VAL_W-1:0]  value;
        logic              err;
    } t_cmd;

    // One tree node as stored in memory.
    typedef struct packed {
        logic [VAL_W-1:0] max_v;
        logic [VAL_W-1:0] pend;
    } t_entry;

    // Memory access request from the walker.
    typedef struct packed {
        logic               we;
        logic [NODE_AW-1:0] waddr;
        t_entry             wdata;
        logic [NODE_AW-1:0] raddr;
    } t_mem_req;

    // One result word.
    typedef struct packed {
        logic [VAL_W-1:0] max_value;
        logic             range_error;
    } t_result;

    // Signed maximum of two 64-bit words.
    function automatic logic [VAL_W-1:0] f_smax(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
        return ($signed(a) >= $signed(b)) ? a : b;
    endfunction

endpackage

[hw/rtl/ratree_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
module ratree_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/ratree_walk.sv]
// Tree walker: clears the node memory after reset and runs one operation at a time.
module ratree_walk (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  ratree_pkg::t_cmd    i_cmd,
    input  logic                i_take,
    input  ratree_pkg::t_entry  i_rdata,
    output ratree_pkg::t_mem_req o_mem,
    output logic                o_idle,
    output logic                o_done,
    output ratree_pkg::t_result o_result
);
    import ratree_pkg::*;

    typedef enum logic [12:0] {
        S_CLEAR  = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_ENTER  = 13'b0000000000100,
        S_EVAL   = 13'b0000000001000,
        S_PD_L   = 13'b0000000010000,
        S_PD_R   = 13'b0000000100000,
        S_DESC   = 13'b0000001000000,
        S_RET    = 13'b0000010000000,
        S_ASC    = 13'b0000100000000,
        S_PULL   = 13'b0001000000000,
        S_PULL_L = 13'b0010000000000,
        S_PULL_R = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } t_state;

    t_state             r_state, n_state;
    logic [NODE_AW-1:0] r_clr, n_clr;
    logic [NODE_AW-1:0] r_node, n_node;
    logic [LVL_W-1:0]   r_level, n_level;
    t_cmd               r_cmd, n_cmd;
    logic [VAL_W-1:0]   r_t, n_t;
    logic [VAL_W-1:0]   r_acc, n_acc;
    logic               r_have, n_have;
    logic               r_from_left, n_from_left;

    logic [LVL_W-1:0]   sh;
    logic [NODE_AW-1:0] node_shift;
    logic [IDX_W-1:0]   span_mask;
    logic [IDX_W-1:0]   span_lo;
    logic [IDX_W-1:0]   span_hi;
    logic [IDX_W-1:0]   span_mid;
    logic               covered;
    logic               leaf;
    logic [NODE_AW-1:0] child_l;
    logic [NODE_AW-1:0] child_r;

    // Span of the current node, derived from its index and level.
    always_comb begin
        sh         = LVL_W'(LEVELS) - r_level;
        node_shift = r_node << sh;
        span_mask  = ~({IDX_W{1'b1}} << sh);
        span_lo    = node_shift[IDX_W-1:0];
        span_hi    = span_lo | span_mask;
        span_mid   = span_lo | (span_mask >> 1);
        covered    = (span_lo >= r_cmd.lo) && (span_hi <= r_cmd.hi);
        leaf       = (r_level == LVL_W'(LEVELS));
        child_l    = {r_node[NODE_AW-2:0], 1'b0};
        child_r    = {r_node[NODE_AW-2:0], 1'b1};
    end

    // Walk sequencer: one memory read and one write per cycle at most.
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_node      = r_node;
        n_level     = r_level;
        n_cmd       = r_cmd;
        n_t         = r_t;
        n_acc       = r_acc;
        n_have      = r_have;
        n_from_left = r_from_left;
        o_mem       = '0;
        case (r_state)
            S_CLEAR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_clr;
                o_mem.wdata = '0;
                n_clr       = r_clr + NODE_AW'(1);
                if (r_clr == {NODE_AW{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_cmd   = i_cmd;
                    n_node  = NODE_AW'(1);
                    n_level = '0;
                    n_acc   = '0;
                    n_have  = 1'b0;
                    if (i_cmd.err || !(i_cmd.mode inside {MODE_SET, MODE_ADD, MODE_QUERY})) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_ENTER;
                    end
                end
            end
            S_ENTER: begin
                o_mem.raddr = r_node;
                n_state     = S_EVAL;
            end
            S_EVAL: begin
                if (r_cmd.mode == MODE_SET && leaf) begin
                    o_mem.we          = 1'b1;
                    o_mem.waddr       = r_node;
                    o_mem.wdata.max_v = r_cmd.value;
                    o_mem.wdata.pend  = '0;
                    n_state           = S_RET;
                end else if (r_cmd.mode == MODE_ADD && covered) begin
                    o_mem.we          = 1'b1;
                    o_mem.waddr       = r_node;
                    o_mem.wdata.max_v = i_rdata.max_v + r_cmd.value;
                    o_mem.wdata.pend  = i_rdata.pend + r_cmd.value;
                    n_state           = S_RET;
                end else if (r_cmd.mode == MODE_QUERY && covered) begin
                    n_acc   = r_have ? f_smax(r_acc, i_rdata.max_v) : i_rdata.max_v;
                    n_have  = 1'b1;
                    n_state = S_RET;
                end else if (i_rdata.pend != '0) begin
                    // Push the pending add: clear it here and start on the left child.
                    n_t               = i_rdata.pend;
                    o_mem.we          = 1'b1;
                    o_mem.waddr       = r_node;
                    o_mem.wdata.max_v = i_rdata.max_v;
                    o_mem.wdata.pend  = '0;
                    o_mem.raddr       = child_l;
                    n_state           = S_PD_L;
                end else begin
                    n_state = S_DESC;
                end
            end
            S_PD_L: begin
                o_mem.we          = 1'b1;
                o_mem.waddr       = child_l;
                o_mem.wdata.max_v = i_rdata.max_v + r_t;
                o_mem.wdata.pend  = i_rdata.pend + r_t;
                o_mem.raddr       = child_r;
                n_state           = S_PD_R;
            end
            S_PD_R: begin
                o_mem.we          = 1'b1;
                o_mem.waddr       = child_r;
                o_mem.wdata.max_v = i_rdata.max_v + r_t;
                o_mem.wdata.pend  = i_rdata.pend + r_t;
                n_state           = S_DESC;
            end
            S_DESC: begin
                // The first index picks the side: left when it lies at or below mid.
                n_node      = (r_cmd.lo <= span_mid) ? child_l : child_r;
                n_level     = r_level + LVL_W'(1);
                o_mem.raddr = n_node;
                n_state     = S_EVAL;
            end
            S_RET: begin
                if (r_node == NODE_AW'(1)) begin
                    n_state = S_DONE;
                end else begin
                    n_from_left = ~r_node[0];
                    n_node      = r_node >> 1;
                    n_level     = r_level - LVL_W'(1);
                    n_state     = S_ASC;
                end
            end
            S_ASC: begin
                if (r_cmd.mode != MODE_SET && r_from_left && r_cmd.hi > span_mid) begin
                    n_node      = child_r;
                    n_level     = r_level + LVL_W'(1);
                    o_mem.raddr = child_r;
                    n_state     = S_EVAL;
                end else if (r_cmd.mode == MODE_QUERY) begin
                    n_state = S_RET;
                end else begin
                    n_state = S_PULL;
                end
            end
            S_PULL: begin
                o_mem.raddr = child_l;
                n_state     = S_PULL_L;
            end
            S_PULL_L: begin
                n_t         = i_rdata.max_v;
                o_mem.raddr = child_r;
                n_state     = S_PULL_R;
            end
            S_PULL_R: begin
                // The pending add of a node on the path is already zero here.
                o_mem.we          = 1'b1;
                o_mem.waddr       = r_node;
                o_mem.wdata.max_v = f_smax(r_t, i_rdata.max_v);
                o_mem.wdata.pend  = '0;
                n_state           = S_RET;
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    // Working registers of the current operation.
    always_ff @(posedge i_clk) begin
        r_node      <= n_node;
        r_level     <= n_level;
        r_cmd       <= n_cmd;
        r_t         <= n_t;
        r_acc       <= n_acc;
        r_have      <= n_have;
        r_from_left <= n_from_left;
    end

    assign o_idle               = (r_state == S_IDLE);
    assign o_done               = (r_state == S_DONE);
    assign o_result.max_value   = r_acc;
    assign o_result.range_error = r_cmd.err;

endmodule

[hw/rtl/range_add_range_max_tree.sv]
// Range-add range-maximum tree: top level with configuration, checks and output register.
//
// Holds 1024 signed 64-bit elements in a segment tree of maxima with pending-add tags,
// stored as one 2048-entry node memory (maximum and pending add per node). Each word is a
// point set, a range add or a range maximum query, and gives one result word. After reset
// the block sweeps the node memory to zero, one node a cycle, before it takes the first word.
// Words are handled one at a time by a sequencer that walks the tree top down through the
// single read and write port of that memory: each visited node is read on the way down and
// its pending add, when not zero, is pushed to both children; for a set or an add its
// maximum is refreshed from both children on the way back. Range operations touch up to
// four nodes a level. A rejected word skips the walk. A finished result waits in the output
// register while the next word is taken.
module range_add_range_max_tree (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ratree_pkg::CNT_W-1:0]         i_cfg_wdata,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [ratree_pkg::MODE_W-1:0]        i_mode,
    input  logic [ratree_pkg::IDX_W-1:0]         i_range_low,
    input  logic [ratree_pkg::IDX_W-1:0]         i_range_high,
    input  logic signed [ratree_pkg::AMT_W-1:0]  i_amount,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [ratree_pkg::VAL_W-1:0]  o_max_value,
    output logic                                 o_range_error
);
    import ratree_pkg::*;

    logic [CNT_W-1:0] r_elem_count;
    logic [CNT_W-1:0] count_used;
    logic             in_err;
    logic             start;
    logic             take;
    logic             w_idle;
    logic             w_done;
    t_cmd             cmd;
    t_result          w_result;
    t_mem_req         mem_req;
    t_entry           mem_rdata;
    logic             r_out_valid;
    t_result          r_out;

    // Element count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            r_elem_count <= i_cfg_wdata;
        end
    end

    // Range checks against the count in use.
    always_comb begin
        count_used = (r_elem_count > COUNT_RESET) ? COUNT_RESET : r_elem_count;
        case (i_mode)
            MODE_SET: begin
                in_err = ({1'b0, i_range_low} >= count_used);
            end
            MODE_ADD, MODE_QUERY: begin
                in_err = (i_range_low > i_range_high) || ({1'b0, i_range_high} >= count_used);
            end
            default: begin
                in_err = 1'b0;
            end
        endcase
        cmd.mode  = i_mode;
        cmd.lo    = i_range_low;
        cmd.hi    = i_range_high;
        cmd.value = VAL_W'(i_amount);
        cmd.err   = in_err;
    end

    assign o_ready = w_idle;
    assign start   = i_valid && w_idle;
    assign take    = w_done && (!r_out_valid || i_ready);

    ratree_walk u_walk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cmd    (cmd),
        .i_take   (take),
        .i_rdata  (mem_rdata),
        .o_mem    (mem_req),
        .o_idle   (w_idle),
        .o_done   (w_done),
        .o_result (w_result)
    );

    ratree_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (NODES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= w_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_max_value   = r_out.max_value;
    assign o_range_error = r_out.range_error;

endmodule

[hw/rtl/ratree_chk.sv]
// Port-level checker for the range-add range-maximum tree, bound to the top level.
`include "range_add_range_max_tree_assert.svh"

module ratree_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_ready,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic signed [ratree_pkg::VAL_W-1:0] o_max_value,
    input logic                                o_range_error
);
    import ratree_pkg::*;

    // A pending result word stays until it is taken.
    `RATREE_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid)

    // A rejected word always reports a zero maximum.
    `RATREE_ASSERT_NOW(a_err_zero, o_valid && o_range_error, o_max_value == '0)

    // One word at a time: the block is busy right after it takes one.
    `RATREE_ASSERT_NEXT(a_one_at_time, i_valid && o_ready, !o_ready)

    // Reset leaves no result and holds off input for the memory sweep.
    `RATREE_ASSERT_NEXT_ALL(a_reset_quiet, !i_rst_n, !o_valid && !o_ready)

endmodule

bind range_add_range_max_tree ratree_chk u_chk (.*);

[tb/sv/tb_range_add_range_max_tree.sv]
// Testbench for the range-add range-maximum tree: directed and random words checked in order.
`timescale 1ns / 1ps

module tb_range_add_range_max_tree;
    import ratree_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int MAX_REPORTS = 10;

    // Expected result word.
    typedef struct {
        logic [VAL_W-1:0] max_value;
        logic             range_error;
    } t_expect;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CNT_W-1:0]         i_cfg_wdata;
    logic                     i_valid;
    logic                     o_ready;
    logic [MODE_W-1:0]        i_mode;
    logic [IDX_W-1:0]         i_range_low;
    logic [IDX_W-1:0]         i_range_high;
    logic signed [AMT_W-1:0]  i_amount;
    logic                     o_valid;
    logic                     i_ready;
    logic signed [VAL_W-1:0]  o_max_value;
    logic                     o_range_error;

    // Local copy of the element store and the count register.
    logic [VAL_W-1:0] elem_store [LEAVES];
    int unsigned      elem_count;

    t_expect     expected_words [$];
    int          mismatch_count;
    int          words_sent;
    int          words_checked;
    int          send_idle_pct;
    int          recv_stall_pct;
    longint      cycle_count;

    range_add_range_max_tree u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .i_amount     (i_amount),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_max_value  (o_max_value),
        .o_range_error(o_range_error)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Cycle counter with a generous timeout.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Predict one word; the flat store gives the same maxima as the tree does.
    function automatic t_expect predict_tree_word(input logic [MODE_W-1:0] mode,
                                                  input int unsigned lo, input int unsigned hi,
                                                  input logic [AMT_W-1:0] amt);
        t_expect          res;
        logic [VAL_W-1:0] ext;
        int unsigned      cnt;
        res.max_value   = '0;
        res.range_error = 1'b0;
        ext = {{(VAL_W-AMT_W){amt[AMT_W-1]}}, amt};
        cnt = (elem_count > LEAVES) ? LEAVES : elem_count;
        if (mode == MODE_SET) begin
            if (lo >= cnt) res.range_error = 1'b1;
            else elem_store[lo] = ext;
        end else if (mode == MODE_ADD || mode == MODE_QUERY) begin
            if (lo > hi || hi >= cnt) begin
                res.range_error = 1'b1;
            end else if (mode == MODE_ADD) begin
                for (int i = lo; i <= hi; i++) elem_store[i] = elem_store[i] + ext;
            end else begin
                res.max_value = elem_store[lo];
                for (int i = lo + 1; i <= hi; i++)
                    if ($signed(elem_store[i]) > $signed(res.max_value))
                        res.max_value = elem_store[i];
            end
        end
        return res;
    endfunction

    // Send one word, with optional idle cycles before it. Valid stays high after the
    // accepting edge until the next word or an idle cycle replaces it.
    task automatic send_word(input logic [MODE_W-1:0] mode, input int unsigned lo,
                             input int unsigned hi, input logic [AMT_W-1:0] amt);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_mode       <= mode;
        i_range_low  <= lo[IDX_W-1:0];
        i_range_high <= hi[IDX_W-1:0];
        i_amount     <= amt;
        expected_words.push_back(predict_tree_word(mode, lo, hi, amt));
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        words_sent++;
    endtask

    // Drop valid, wait until all results are in, then let the block settle.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    // Write the count register while the block is idle.
    task automatic write_count(input int unsigned value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[CNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        elem_count = value & 11'h7FF;
    endtask

    function automatic logic [AMT_W-1:0] rand_amount();
        case ($urandom_range(4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return AMT_W'($urandom_range(20)) - 32'd10;
            default: return $urandom;
        endcase
    endfunction

    // Result checker: receiver stalls at random and compares against the oldest expectation.
    always @(posedge i_clk) begin
        t_expect exp_word;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_words.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("Unexpected result word max=%0d err=%0b",
                                 o_max_value, o_range_error);
                end else begin
                    exp_word = expected_words.pop_front();
                    words_checked++;
                    if (o_max_value !== exp_word.max_value ||
                        o_range_error !== exp_word.range_error) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("Mismatch: expected max=%0d err=%0b, got max=%0d err=%0b",
                                     $signed(exp_word.max_value), exp_word.range_error,
                                     o_max_value, o_range_error);
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Directed words: field extremes, every mode and each rejection case.
    task automatic test_directed();
        send_word(MODE_QUERY, 0, 1023, 0);
        send_word(MODE_SET, 0, 0, 32'h7FFF_FFFF);
        send_word(MODE_SET, 1023, 0, 32'h8000_0000);
        send_word(MODE_ADD, 0, 1023, 32'h7FFF_FFFF);
        send_word(MODE_ADD, 512, 1023, 32'hFFFF_FFFF);
        send_word(MODE_QUERY, 0, 0, 0);
        send_word(MODE_QUERY, 1023, 1023, 0);
        send_word(MODE_QUERY, 1, 1022, 32'hFFFF_FFFF);
        send_word(MODE_ADD, 5, 4, 100);
        send_word(MODE_QUERY, 700, 300, 0);
        send_word(MODE_UNUSED, 1023, 0, 32'hFFFF_FFFF);
        send_word(MODE_QUERY, 0, 1023, 0);
        write_count(1);
        send_word(MODE_SET, 1, 0, 9);
        send_word(MODE_QUERY, 0, 1, 0);
        send_word(MODE_QUERY, 0, 0, 0);
        write_count(0);
        send_word(MODE_SET, 0, 0, 1);
        send_word(MODE_ADD, 0, 0, 1);
        send_word(MODE_UNUSED, 0, 0, 0);
        write_count(2047);
        send_word(MODE_ADD, 0, 1023, 32'h8000_0000);
        send_word(MODE_QUERY, 0, 1023, 0);
    endtask

    // Random words, mostly valid ranges with some rejected ones.
    task automatic test_random(input int n_words, input int idle_pct, input int stall_pct);
        int unsigned lo, hi, cnt, mode;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        cnt = (elem_count > LEAVES) ? LEAVES : elem_count;
        for (int k = 0; k < n_words; k++) begin
            mode = $urandom_range(9);
            mode = (mode < 3) ? MODE_SET : (mode < 6) ? MODE_ADD :
                   (mode < 9) ? MODE_QUERY : $urandom_range(3);
            if ($urandom_range(9) == 0 || cnt == 0) begin
                lo = $urandom_range(1023);
                hi = $urandom_range(1023);
            end else begin
                lo = $urandom_range(cnt - 1);
                hi = ($urandom_range(3) == 0) ? $urandom_range(cnt - 1, lo)
                                               : $urandom_range((lo + 8 < cnt) ? lo + 8
                                                                : cnt - 1, lo);
            end
            send_word(mode[MODE_W-1:0], lo, hi, rand_amount());
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        i_valid      = 1'b0;
        i_mode       = '0;
        i_range_low  = '0;
        i_range_high = '0;
        i_amount     = '0;
        mismatch_count = 0;
        words_sent     = 0;
        words_checked  = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        elem_count     = LEAVES;
        for (int i = 0; i < LEAVES; i++) elem_store[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(130, 0, 0);
        write_count(37);
        test_random(130, 57, 0);
        write_count(1024);
        test_random(130, 0, 57);
        write_count(600);
        test_random(130, 20, 20);
        drain_results();

        $display("Sent %0d words and checked %0d results over counts 0 to 2047,",
                 words_sent, words_checked);
        $display("with idle and stall phases; %0d mismatches.", mismatch_count);
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
